@@ rtl/assert_macros.svh @@
// Shared assertion macros for the rtl tree.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define Q2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication, checked outside reset.
`define Q2E_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/q2e_pkg.sv @@
// ----------------------------------------------------------------------------
// q2e_pkg
// Types, constants and tables shared by the quaternion to Euler converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ACC_FRAC        = 20;
  localparam int RND_SHIFT       = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int STEPS           = 21;
  localparam int ARG_W           = 34;  // Q2.30 args times two, signed
  localparam int CORD_W          = 37;  // CORDIC x/y with gain headroom
  localparam int ACC_W           = 30;  // angle in 2^-20 degree
  localparam int UNIT_W          = ACC_W + 1 - RND_SHIFT;
  localparam int ROOT_W          = 31;
  localparam int SQRT_STAGES     = ROOT_W;
  localparam int RAD_W           = 62;
  localparam int LATENCY         = 4 + SQRT_STAGES + 1 + STEPS + 1;

  localparam logic signed [ARG_W-1:0]  ONE    = ARG_W'(64'sd1073741824);
  localparam logic signed [ACC_W-1:0]  DEG180 = ACC_W'(180 * (1 << ACC_FRAC));
  localparam logic signed [UNIT_W-1:0] LIM90  = UNIT_W'(90 * (1 << ANGLE_FRAC_BITS));
  localparam logic signed [UNIT_W-1:0] LIM180 = UNIT_W'(180 * (1 << ANGLE_FRAC_BITS));

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic signed [14:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               gimbal_clamped;
  } angles_t;

  // atan(2^-i) in degrees, scaled by 2^20
  function automatic logic signed [ACC_W-1:0] atan_step(input logic [4:0] i);
    logic signed [ACC_W-1:0] v;
    case (i)
      5'd0:  v = ACC_W'(47185920);
      5'd1:  v = ACC_W'(27855475);
      5'd2:  v = ACC_W'(14718068);
      5'd3:  v = ACC_W'(7471121);
      5'd4:  v = ACC_W'(3750058);
      5'd5:  v = ACC_W'(1876857);
      5'd6:  v = ACC_W'(938658);
      5'd7:  v = ACC_W'(469357);
      5'd8:  v = ACC_W'(234682);
      5'd9:  v = ACC_W'(117342);
      5'd10: v = ACC_W'(58671);
      5'd11: v = ACC_W'(29335);
      5'd12: v = ACC_W'(14668);
      5'd13: v = ACC_W'(7334);
      5'd14: v = ACC_W'(3667);
      5'd15: v = ACC_W'(1833);
      5'd16: v = ACC_W'(917);
      5'd17: v = ACC_W'(458);
      5'd18: v = ACC_W'(229);
      5'd19: v = ACC_W'(115);
      5'd20: v = ACC_W'(57);
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up to output units, then clamp to +-lim
  function automatic logic signed [UNIT_W-1:0] to_units(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [UNIT_W-1:0] lim);
    logic signed [ACC_W:0]    t;
    logic signed [UNIT_W-1:0] r;
    t = {acc[ACC_W-1], acc} + (ACC_W+1)'(1 << (RND_SHIFT - 1));
    r = t[ACC_W:RND_SHIFT];
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

endpackage

@@ rtl/quaternion_to_euler_angles_top.sv @@
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Q1.15 quaternion in, roll/pitch/yaw in 1/128 degree out.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: quat (w, x, y, z) is taken on a clock edge with start high
//   and busy low. busy is always low: the datapath is a fixed pipeline.
//   Output word: result is shown for exactly one cycle with done high.
//   Pipeline: products, sums, square, radicand, square root 31
//   stages at one root bit each, CORDIC fold, 21 vectoring stages, round
//   and clamp. Throughput: one word per cycle, set by the fully staged
//   square root and CORDIC units.
//   Roll is asin(s) as atan2(s, sqrt(1 - s^2)); when |s| >= 1 it is held at
//   +-90 degrees and gimbal_clamped is set.
//   Reset clears only the valid chain; words in flight are dropped.
//   The receiver cannot stall; every done pulse must be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_to_euler_angles_top import q2e_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  quat_t   quat,
  output logic    done,
  output angles_t result
);

  logic [LATENCY-1:0] vld;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], start && !busy};
    end
  end
  assign done = vld[LATENCY-1];

  // stage 1: products, Q2.30
  logic signed [31:0] p_wy, p_zx, p_wx, p_yz, p_wz, p_xy, p_xx, p_yy, p_zz;
  always_ff @(posedge clk) begin
    p_wy <= quat.quat_w * quat.quat_y;
    p_zx <= quat.quat_z * quat.quat_x;
    p_wx <= quat.quat_w * quat.quat_x;
    p_yz <= quat.quat_y * quat.quat_z;
    p_wz <= quat.quat_w * quat.quat_z;
    p_xy <= quat.quat_x * quat.quat_y;
    p_xx <= quat.quat_x * quat.quat_x;
    p_yy <= quat.quat_y * quat.quat_y;
    p_zz <= quat.quat_z * quat.quat_z;
  end

  // stage 2: atan2 arguments
  logic signed [ARG_W-1:0] s2, py2, px2, yy2, yx2;
  always_ff @(posedge clk) begin
    s2  <= (ARG_W'(p_wy) - ARG_W'(p_zx)) <<< 1;
    py2 <= (ARG_W'(p_wx) + ARG_W'(p_yz)) <<< 1;
    px2 <= ONE - ((ARG_W'(p_xx) + ARG_W'(p_yy)) <<< 1);
    yy2 <= (ARG_W'(p_wz) + ARG_W'(p_xy)) <<< 1;
    yx2 <= ONE - ((ARG_W'(p_yy) + ARG_W'(p_zz)) <<< 1);
  end

  // stage 3: s^2 (only meaningful when |s| < 1) and clamp decision
  logic [ARG_W-1:0] s_mag;
  logic [59:0]      sq3;
  logic signed [ARG_W-1:0] s3, py3, px3, yy3, yx3;
  logic hi3, lo3;
  assign s_mag = s2[ARG_W-1] ? ARG_W'(-s2) : ARG_W'(s2);
  always_ff @(posedge clk) begin
    sq3 <= s_mag[29:0] * s_mag[29:0];
    hi3 <= s2 >= ONE;
    lo3 <= s2 <= -ONE;
    s3  <= s2;
    py3 <= py2;
    px3 <= px2;
    yy3 <= yy2;
    yx3 <= yx2;
  end

  // square root shift line, index 0 is the radicand stage
  logic [RAD_W-1:0]        rem_q  [0:SQRT_STAGES];
  logic [ROOT_W-1:0]       root_q [0:SQRT_STAGES];
  logic signed [ARG_W-1:0] s_q    [0:SQRT_STAGES];
  logic signed [ARG_W-1:0] py_q   [0:SQRT_STAGES];
  logic signed [ARG_W-1:0] px_q   [0:SQRT_STAGES];
  logic signed [ARG_W-1:0] yy_q   [0:SQRT_STAGES];
  logic signed [ARG_W-1:0] yx_q   [0:SQRT_STAGES];
  logic [1:0]              cl_q   [0:SQRT_STAGES];

  // stage 4: radicand 2^60 - s^2
  always_ff @(posedge clk) begin
    rem_q[0]  <= (RAD_W'(1) << 60) - RAD_W'(sq3);
    root_q[0] <= '0;
    s_q[0]    <= s3;
    py_q[0]   <= py3;
    px_q[0]   <= px3;
    yy_q[0]   <= yy3;
    yx_q[0]   <= yx3;
    cl_q[0]   <= {hi3, lo3};
  end

  // one root bit per stage, bit k = ROOT_W-1-j
  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
    localparam int K = ROOT_W - 1 - j;
    logic [RAD_W-1:0] trial;
    logic             ge;
    assign trial = (RAD_W'(root_q[j]) << (K + 1)) | (RAD_W'(1) << (2 * K));
    assign ge    = rem_q[j] >= trial;
    always_ff @(posedge clk) begin
      rem_q[j+1]  <= ge ? rem_q[j] - trial : rem_q[j];
      root_q[j+1] <= ge ? (root_q[j] | (ROOT_W'(1) << K)) : root_q[j];
      s_q[j+1]    <= s_q[j];
      py_q[j+1]   <= py_q[j];
      px_q[j+1]   <= px_q[j];
      yy_q[j+1]   <= yy_q[j];
      yx_q[j+1]   <= yx_q[j];
      cl_q[j+1]   <= cl_q[j];
    end
  end

  logic signed [ARG_W-1:0] cos_arg;
  logic signed [ACC_W-1:0] roll_acc, pitch_acc, yaw_acc;
  assign cos_arg = signed'({(ARG_W-ROOT_W)'(0), root_q[SQRT_STAGES]});

  q2e_cordic u_roll (
    .clk   (clk),
    .y_in  (s_q[SQRT_STAGES]),
    .x_in  (cos_arg),
    .angle (roll_acc)
  );

  q2e_cordic u_pitch (
    .clk   (clk),
    .y_in  (py_q[SQRT_STAGES]),
    .x_in  (px_q[SQRT_STAGES]),
    .angle (pitch_acc)
  );

  q2e_cordic u_yaw (
    .clk   (clk),
    .y_in  (yy_q[SQRT_STAGES]),
    .x_in  (yx_q[SQRT_STAGES]),
    .angle (yaw_acc)
  );

  // clamp flags ride alongside the CORDIC
  logic [1:0] cl_d [0:STEPS];
  always_ff @(posedge clk) begin
    cl_d[0] <= cl_q[SQRT_STAGES];
  end
  for (genvar i = 0; i < STEPS; i++) begin : g_cl
    always_ff @(posedge clk) begin
      cl_d[i+1] <= cl_d[i];
    end
  end

  logic signed [UNIT_W-1:0] roll_u, pitch_u, yaw_u, yaw_neg;
  logic                     clamp_hi, clamp_lo;
  assign clamp_hi = cl_d[STEPS][1];
  assign clamp_lo = cl_d[STEPS][0];
  assign pitch_u  = to_units(pitch_acc, LIM180);
  assign yaw_u    = to_units(yaw_acc, LIM180);
  assign yaw_neg  = -yaw_u;

  always_comb begin
    if (clamp_hi) begin
      roll_u = LIM90;
    end else if (clamp_lo) begin
      roll_u = -LIM90;
    end else begin
      roll_u = to_units(roll_acc, LIM90);
    end
  end

  always_ff @(posedge clk) begin
    result.roll_angle     <= roll_u[14:0];
    result.pitch_angle    <= pitch_u[15:0];
    result.yaw_angle      <= yaw_neg[15:0];
    result.gimbal_clamped <= clamp_hi | clamp_lo;
  end

  `Q2E_ASSERT_IMP(a_done_src, done, $past(start && !busy, LATENCY),
                  "done without a matching accepted word")
  `Q2E_ASSERT_IMP(a_clamp_roll, done && result.gimbal_clamped,
                  result.roll_angle == 15'sd11520 || result.roll_angle == -15'sd11520,
                  "clamped word not at +-90 degrees")
  `Q2E_ASSERT_IMP(a_roll_rng, done,
                  result.roll_angle <= 15'sd11520 && result.roll_angle >= -15'sd11520,
                  "roll out of range")
  `Q2E_ASSERT_IMP(a_py_rng, done,
                  result.pitch_angle <= 16'sd23040 && result.pitch_angle >= -16'sd23040
                  && result.yaw_angle <= 16'sd23040 && result.yaw_angle >= -16'sd23040,
                  "pitch or yaw out of range")

endmodule

@@ rtl/q2e_cordic.sv @@
// ----------------------------------------------------------------------------
// q2e_cordic
// Pipelined atan2(y, x): half-plane fold stage, then one vectoring step per
// register stage. Angle out in 2^-20 degree.
// ----------------------------------------------------------------------------
module q2e_cordic import q2e_pkg::*; (
  input  logic                    clk,
  input  logic signed [ARG_W-1:0] y_in,
  input  logic signed [ARG_W-1:0] x_in,
  output logic signed [ACC_W-1:0] angle
);

  logic signed [CORD_W-1:0] xs [0:STEPS];
  logic signed [CORD_W-1:0] ys [0:STEPS];
  logic signed [ACC_W-1:0]  ac [0:STEPS];
  logic                     zr [0:STEPS];

  always_ff @(posedge clk) begin
    zr[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      ac[0] <= (y_in >= 0) ? DEG180 : -DEG180;
      xs[0] <= -CORD_W'(x_in);
      ys[0] <= -CORD_W'(y_in);
    end else begin
      ac[0] <= '0;
      xs[0] <= CORD_W'(x_in);
      ys[0] <= CORD_W'(y_in);
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CORD_W-1:0] dx, dy;
    assign dx = ys[i] >>> i;
    assign dy = xs[i] >>> i;
    always_ff @(posedge clk) begin
      zr[i+1] <= zr[i];
      if (!ys[i][CORD_W-1]) begin
        xs[i+1] <= xs[i] + dx;
        ys[i+1] <= ys[i] - dy;
        ac[i+1] <= ac[i] + atan_step(5'(i));
      end else begin
        xs[i+1] <= xs[i] - dx;
        ys[i+1] <= ys[i] + dy;
        ac[i+1] <= ac[i] - atan_step(5'(i));
      end
    end
  end

  // both args zero gives zero angle
  assign angle = zr[STEPS] ? '0 : ac[STEPS];

endmodule
